// ===== hdl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg
// Types, codes and helpers shared by the sorted schedule table.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int SST_DEPTH    = 16;
  localparam int ENTRY_W      = 32;
  localparam int KEY_W        = 11;
  localparam int MIN_PER_HOUR = 60;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_CHANGE = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_FULL   = 2'd1;
  localparam logic [1:0] STATUS_BADIDX = 2'd2;

  typedef struct packed {
    logic [13:0] mass;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [6:0]  day;
  } entry_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] slot;
    entry_t     entry;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] entry_count;
    logic [3:0] landed_at;
    entry_t     entry;
  } res_t;

  // minute of day: hour*60 + minute
  function automatic logic [KEY_W-1:0] entry_key(entry_t e);
    return KEY_W'(e.hour) * KEY_W'(MIN_PER_HOUR) + KEY_W'(e.minute);
  endfunction

endpackage

// ===== hdl/sst_ram.sv =====
// ----------------------------------------------------------------------------
// sst_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/sst_ctrl.sv =====
// ----------------------------------------------------------------------------
// sst_ctrl
// Request sequencer: reads, shifts and writes back table entries in the RAM.
// ----------------------------------------------------------------------------
module sst_ctrl import sst_pkg::*; #(
  parameter int TABLE_DEPTH = SST_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           req_valid,
  input  req_t                           req,
  output logic                           busy,
  output logic                           res_valid,
  output res_t                           res,
  input  logic                           res_take,
  output logic                           ram_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
  output logic [ENTRY_W-1:0]             ram_wdata,
  output logic                           ram_re,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
  input  logic [ENTRY_W-1:0]             ram_rdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = (CW > 4) ? CW : 4;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_DEL  = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    ptr_r, ptr_nxt;
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic             pend_r, pend_nxt;
  logic [1:0]       kind_r, kind_nxt;
  entry_t           entry_r, entry_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [AW-1:0]    landed_r, landed_nxt;
  entry_t           rd_r, rd_nxt;

  logic          slot_ok;
  logic [CW-1:0] ptr_dec;
  logic [AW-1:0] wptr_inc;
  logic          moving;

  assign slot_ok  = SW'(req.slot) < SW'(count_r);
  assign ptr_dec  = ptr_r - 1'b1;
  assign wptr_inc = wptr_r + 1'b1;
  assign moving   = entry_key(entry_t'(ram_rdata)) > key_r;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    wptr_nxt   = wptr_r;
    pend_nxt   = pend_r;
    kind_nxt   = kind_r;
    entry_nxt  = entry_r;
    key_nxt    = key_r;
    status_nxt = status_r;
    landed_nxt = landed_r;
    rd_nxt     = rd_r;
    ram_we     = 1'b0;
    ram_waddr  = wptr_r;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = ptr_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          entry_nxt  = req.entry;
          key_nxt    = entry_key(req.entry);
          kind_nxt   = req.kind;
          status_nxt = STATUS_OK;
          landed_nxt = '0;
          rd_nxt     = '0;
          pend_nxt   = 1'b0;
          unique case (req.kind) inside
            KIND_ADD: begin
              if (count_r == CW'(TABLE_DEPTH)) begin
                status_nxt = STATUS_FULL;
                state_nxt  = S_DONE;
              end else begin
                ptr_nxt   = count_r;
                state_nxt = S_INS;
              end
            end
            KIND_CHANGE, KIND_DELETE: begin
              if (!slot_ok) begin
                status_nxt = STATUS_BADIDX;
                state_nxt  = S_DONE;
              end else begin
                ptr_nxt   = CW'(req.slot) + 1'b1;
                state_nxt = S_DEL;
              end
            end
            KIND_READ: begin
              if (!slot_ok) begin
                status_nxt = STATUS_BADIDX;
                state_nxt  = S_DONE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(req.slot);
                state_nxt = S_READ;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_READ: begin
        rd_nxt    = entry_t'(ram_rdata);
        state_nxt = S_DONE;
      end

      // close the gap: entry i+1 moves down to i
      S_DEL: begin
        if (pend_r) begin
          ram_we = 1'b1;
        end
        if (ptr_r < count_r) begin
          ram_re    = 1'b1;
          wptr_nxt  = ptr_r[AW-1:0] - 1'b1;
          ptr_nxt   = ptr_r + 1'b1;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt = count_r - 1'b1;
            if (kind_r == KIND_CHANGE) begin
              ptr_nxt   = count_r - 1'b1;
              state_nxt = S_INS;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end
      end

      // scan down from the top, moving larger keys up one place
      S_INS: begin
        if (pend_r && !moving) begin
          ram_we     = 1'b1;
          ram_waddr  = wptr_inc;
          ram_wdata  = entry_r;
          landed_nxt = wptr_inc;
          count_nxt  = count_r + 1'b1;
          pend_nxt   = 1'b0;
          state_nxt  = S_DONE;
        end else begin
          if (pend_r) begin
            ram_we    = 1'b1;
            ram_waddr = wptr_inc;
          end
          if (ptr_r != '0) begin
            ram_re    = 1'b1;
            ram_raddr = ptr_dec[AW-1:0];
            wptr_nxt  = ptr_dec[AW-1:0];
            ptr_nxt   = ptr_dec;
            pend_nxt  = 1'b1;
          end else begin
            pend_nxt = 1'b0;
            if (!pend_r) begin
              ram_we     = 1'b1;
              ram_waddr  = '0;
              ram_wdata  = entry_r;
              landed_nxt = '0;
              count_nxt  = count_r + 1'b1;
              state_nxt  = S_DONE;
            end
          end
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    wptr_r   <= wptr_nxt;
    kind_r   <= kind_nxt;
    entry_r  <= entry_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    landed_r <= landed_nxt;
    rd_r     <= rd_nxt;
  end

  assign busy            = state_r != S_IDLE;
  assign res_valid       = state_r == S_DONE;
  assign res.status      = status_r;
  assign res.entry_count = 5'(count_r);
  assign res.landed_at   = 4'(landed_r);
  assign res.entry       = rd_r;

endmodule

// ===== hdl/sorted_schedule_table.sv =====
// ----------------------------------------------------------------------------
// sorted_schedule_table
// Schedule table kept sorted by minute of day, with add, change, delete, read.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in_ channel (valid/stall); one result per request
//   leaves on the out_ channel (valid/stall) through an output register.
//   Entries live in a single RAM with registered read; a request is served by
//   a sequencer that reads, shifts and writes back one entry per cycle.
//   A rejected request (full or bad index) goes straight to its result; a read
//   reads its slot from the RAM; a delete moves each entry above its slot down
//   one place; an add moves entries with larger keys up one place from the top
//   and writes the new entry into the gap; a change is a delete followed by an
//   add on the remaining entries. The shift sweep runs through the RAM port;
//   one request is in the sequencer at a time, and in_stall is high until its
//   result has been taken into the output register.
//   A new request is taken while a finished result waits in the output
//   register; a stalled result holds the sequencer in its final state.
//   Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_schedule_table import sst_pkg::*; #(
  parameter int TABLE_DEPTH = SST_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [3:0]  in_slot,
  input  logic [6:0]  in_day_code,
  input  logic [4:0]  in_hour_value,
  input  logic [5:0]  in_minute_value,
  input  logic [13:0] in_mass_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [4:0]  out_entry_count,
  output logic [3:0]  out_landed_at,
  output logic [6:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [13:0] out_mass
);

  localparam int AW = $clog2(TABLE_DEPTH);

  req_t          req;
  logic          busy;
  logic          res_valid;
  res_t          res;
  logic          res_take;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r, out_res_nxt;

  assign req.kind         = in_kind;
  assign req.slot         = in_slot;
  assign req.entry.day    = in_day_code;
  assign req.entry.hour   = in_hour_value;
  assign req.entry.minute = in_minute_value;
  assign req.entry.mass   = in_mass_value;

  assign in_stall = busy;

  sst_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req       (req),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  sst_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register: loads when empty or when its transfer completes
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_entry_count = out_res_r.entry_count;
  assign out_landed_at   = out_res_r.landed_at;
  assign out_day         = out_res_r.entry.day;
  assign out_hour        = out_res_r.entry.hour;
  assign out_minute      = out_res_r.entry.minute;
  assign out_mass        = out_res_r.entry.mass;

endmodule

// ===== test/sorted_schedule_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_schedule_table_tb
// Self-checking bench for the sorted schedule table.
// A directed table of requests covers the empty table, extreme field values,
// equal times, bad indices and the full table. A long random run follows,
// swinging the table between full and empty. Every result is checked against
// a shadow copy or a fixed value. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module sorted_schedule_table_tb;
  import sst_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 700;
  localparam int SETTLE_CYCLES  = 50;

  typedef struct {
    req_t rq;
    bit   typed;
    res_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [3:0]  in_slot;
  logic [6:0]  in_day_code;
  logic [4:0]  in_hour_value;
  logic [5:0]  in_minute_value;
  logic [13:0] in_mass_value;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [4:0]  out_entry_count;
  logic [3:0]  out_landed_at;
  logic [6:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [13:0] out_mass;

  sorted_schedule_table uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_slot         (in_slot),
    .in_day_code     (in_day_code),
    .in_hour_value   (in_hour_value),
    .in_minute_value (in_minute_value),
    .in_mass_value   (in_mass_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_landed_at   (out_landed_at),
    .out_day         (out_day),
    .out_hour        (out_hour),
    .out_minute      (out_minute),
    .out_mass        (out_mass)
  );

  // shadow copy of the table
  entry_t      shadow_rows [SST_DEPTH];
  int unsigned shadow_used;

  res_t        due_replies[$];
  stim_row_t   directed_rows[$];

  int mismatches;
  int replies_checked;
  int kind_tally [4];
  int full_refusals;
  int bad_slots;
  int times_full;
  int times_empty;
  int tx_mode;
  int rx_mode;
  int rx_hold;
  int rx_ticks;
  int rx_gap;
  int idle_cycles;
  res_t got_reply;
  res_t want_reply;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int minute_of_day(entry_t e);
    return int'(e.hour) * 60 + int'(e.minute);
  endfunction

  function automatic int unsigned place_entry(entry_t e);
    int unsigned pos;
    int unsigned i;
    pos = 0;
    while (pos < shadow_used && minute_of_day(shadow_rows[pos]) <= minute_of_day(e))
      pos++;
    for (i = shadow_used; i > pos; i--)
      shadow_rows[i] = shadow_rows[i-1];
    shadow_rows[pos] = e;
    shadow_used++;
    return pos;
  endfunction

  function automatic void drop_entry(int unsigned pos);
    int unsigned i;
    for (i = pos; i + 1 < shadow_used; i++)
      shadow_rows[i] = shadow_rows[i+1];
    shadow_used--;
  endfunction

  function automatic res_t predict_schedule(req_t rq);
    res_t r;
    r = '0;
    case (rq.kind)
      KIND_ADD: begin
        if (shadow_used >= SST_DEPTH) begin
          r.status = STATUS_FULL;
          full_refusals++;
        end else begin
          r.landed_at = 4'(place_entry(rq.entry));
        end
      end
      KIND_CHANGE: begin
        if (rq.slot >= shadow_used) begin
          r.status = STATUS_BADIDX;
          bad_slots++;
        end else begin
          drop_entry(rq.slot);
          r.landed_at = 4'(place_entry(rq.entry));
        end
      end
      KIND_DELETE: begin
        if (rq.slot >= shadow_used) begin
          r.status = STATUS_BADIDX;
          bad_slots++;
        end else begin
          drop_entry(rq.slot);
        end
      end
      default: begin
        if (rq.slot >= shadow_used) begin
          r.status = STATUS_BADIDX;
          bad_slots++;
        end else begin
          r.entry = shadow_rows[rq.slot];
        end
      end
    endcase
    r.entry_count = 5'(shadow_used);
    return r;
  endfunction

  function automatic entry_t make_entry(int d, int h, int m, int g);
    entry_t e;
    e.day    = 7'(d);
    e.hour   = 5'(h);
    e.minute = 6'(m);
    e.mass   = 14'(g);
    return e;
  endfunction

  function automatic req_t make_req(logic [1:0] k, int s, entry_t e);
    req_t rq;
    rq.kind  = k;
    rq.slot  = 4'(s);
    rq.entry = e;
    return rq;
  endfunction

  function automatic void push_row(req_t rq, bit typed, res_t want);
    stim_row_t row;
    row.rq    = rq;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // mostly no gap, else short gaps and in mode 2 a few long ones; mode 0 gives none
  function automatic int pick_gap(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0 || r < 60)
      return 0;
    if (mode == 1 || r < 94)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // valid stays high on return; the caller lowers it only before a gap
  task automatic post_request(input req_t rq, input bit typed, input res_t want);
    int unsigned was_used;
    res_t predicted;
    in_valid        <= 1'b1;
    in_kind         <= rq.kind;
    in_slot         <= rq.slot;
    in_day_code     <= rq.entry.day;
    in_hour_value   <= rq.entry.hour;
    in_minute_value <= rq.entry.minute;
    in_mass_value   <= rq.entry.mass;
    do @(posedge clk); while (in_stall);
    was_used = shadow_used;
    predicted = predict_schedule(rq);
    due_replies.push_back(typed ? want : predicted);
    kind_tally[rq.kind]++;
    if (shadow_used == SST_DEPTH && was_used != SST_DEPTH)
      times_full++;
    if (shadow_used == 0 && was_used != 0)
      times_empty++;
  endtask

  task automatic idle_sender();
    int g;
    g = pick_gap(tx_mode);
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic req_t random_request(bit filling);
    req_t rq;
    int r;
    int h;
    int m;
    r = $urandom_range(0, 99);
    if (filling)
      rq.kind = (r < 55) ? KIND_ADD : (r < 70) ? KIND_CHANGE : (r < 80) ? KIND_DELETE : KIND_READ;
    else
      rq.kind = (r < 15) ? KIND_ADD : (r < 30) ? KIND_CHANGE : (r < 70) ? KIND_DELETE : KIND_READ;
    if (shadow_used != 0 && $urandom_range(0, 99) < 85)
      rq.slot = 4'($urandom_range(0, shadow_used - 1));
    else
      rq.slot = 4'($urandom_range(0, 15));
    // a small pool of times makes equal keys common
    if ($urandom_range(0, 99) < 40) begin
      case ($urandom_range(0, 3))
        0: h = 0;
        1: h = 7;
        2: h = 23;
        default: h = 31;
      endcase
      case ($urandom_range(0, 2))
        0: m = 0;
        1: m = 30;
        default: m = 63;
      endcase
    end else begin
      h = $urandom_range(0, 31);
      m = $urandom_range(0, 63);
    end
    rq.entry = make_entry($urandom_range(0, 127), h, m, $urandom_range(0, 16383));
    return rq;
  endfunction

  // receiver stall
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      out_stall <= 1'b1;
      rx_hold = rx_hold - 1;
    end else begin
      rx_gap = pick_gap(rx_mode);
      out_stall <= (rx_gap != 0);
      rx_hold = (rx_gap != 0) ? rx_gap - 1 : 0;
    end
    rx_ticks++;
    if (rx_ticks % 200 == 0)
      rx_mode = $urandom_range(0, 2);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_replies.size() == 0) begin
        $display("%0t: unexpected result: status %0d, count %0d", $time, out_status,
                 out_entry_count);
        mismatches++;
      end else begin
        want_reply = due_replies.pop_front();
        got_reply.status      = out_status;
        got_reply.entry_count = out_entry_count;
        got_reply.landed_at   = out_landed_at;
        got_reply.entry       = make_entry(out_day, out_hour, out_minute, out_mass);
        check_field("status", want_reply.status, got_reply.status);
        check_field("entry_count", want_reply.entry_count, got_reply.entry_count);
        check_field("landed_at", want_reply.landed_at, got_reply.landed_at);
        check_field("day", want_reply.entry.day, got_reply.entry.day);
        check_field("hour", want_reply.entry.hour, got_reply.entry.hour);
        check_field("minute", want_reply.entry.minute, got_reply.entry.minute);
        check_field("mass", want_reply.entry.mass, got_reply.entry.mass);
        replies_checked++;
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time,
                 due_replies.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    bit filling;
    int n;
    entry_t top;
    entry_t bottom;
    req_t rq;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_kind         = KIND_ADD;
    in_slot         = '0;
    in_day_code     = '0;
    in_hour_value   = '0;
    in_minute_value = '0;
    in_mass_value   = '0;
    shadow_used     = 0;
    mismatches      = 0;
    replies_checked = 0;
    full_refusals   = 0;
    bad_slots       = 0;
    times_full      = 0;
    times_empty     = 0;
    tx_mode         = 1;
    rx_mode         = 1;
    rx_hold         = 0;
    rx_ticks        = 0;
    idle_cycles     = 0;
    kind_tally      = '{default: 0};

    top    = make_entry(127, 31, 63, 16383);
    bottom = make_entry(0, 0, 0, 0);

    // empty table: every indexed request is refused
    push_row(make_req(KIND_READ, 0, bottom), 1, '{STATUS_BADIDX, 5'd0, 4'd0, '0});
    push_row(make_req(KIND_DELETE, 0, bottom), 1, '{STATUS_BADIDX, 5'd0, 4'd0, '0});
    push_row(make_req(KIND_CHANGE, 15, top), 1, '{STATUS_BADIDX, 5'd0, 4'd0, '0});
    // extremes
    push_row(make_req(KIND_ADD, 15, top), 1, '{STATUS_OK, 5'd1, 4'd0, '0});
    push_row(make_req(KIND_READ, 0, bottom), 1, '{STATUS_OK, 5'd1, 4'd0, top});
    push_row(make_req(KIND_ADD, 0, bottom), 1, '{STATUS_OK, 5'd2, 4'd0, '0});
    // equal times keep arrival order
    push_row(make_req(KIND_ADD, 0, make_entry(5, 0, 0, 1)), 0, '0);
    push_row(make_req(KIND_ADD, 0, make_entry(1, 23, 59, 100)), 0, '0);
    push_row(make_req(KIND_ADD, 0, make_entry(2, 23, 59, 200)), 0, '0);
    push_row(make_req(KIND_READ, 1, bottom), 0, '0);
    push_row(make_req(KIND_READ, 3, bottom), 0, '0);
    push_row(make_req(KIND_CHANGE, 0, make_entry(9, 12, 30, 8191)), 0, '0);
    push_row(make_req(KIND_CHANGE, 4, make_entry(127, 0, 0, 16383)), 0, '0);
    push_row(make_req(KIND_DELETE, 0, bottom), 0, '0);
    push_row(make_req(KIND_DELETE, 3, bottom), 0, '0);
    push_row(make_req(KIND_READ, 3, bottom), 1, '{STATUS_BADIDX, 5'd3, 4'd0, '0});
    for (n = 0; n < 13; n++)
      push_row(make_req(KIND_ADD, 0, make_entry(n, (n * 5) % 32, (n * 23) % 64, n * 1260)),
               0, '0);
    // full table
    push_row(make_req(KIND_ADD, 0, top), 1, '{STATUS_FULL, 5'd16, 4'd0, '0});
    push_row(make_req(KIND_CHANGE, 15, make_entry(3, 0, 1, 77)), 0, '0);
    push_row(make_req(KIND_READ, 15, bottom), 0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      post_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
      idle_sender();
    end

    filling = 1'b1;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0)
        filling = ~filling;
      if (n % 100 == 0)
        tx_mode = $urandom_range(0, 2);
      if (n == RANDOM_ITEMS / 2) begin
        // hold off until the block has answered everything
        in_valid <= 1'b0;
        while (due_replies.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      rq = random_request(filling);
      post_request(rq, 0, '0);
      idle_sender();
    end
    in_valid <= 1'b0;

    while (due_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d adds, %0d changes, %0d deletes, %0d reads; %0d full, %0d bad index.",
             kind_tally[KIND_ADD], kind_tally[KIND_CHANGE], kind_tally[KIND_DELETE],
             kind_tally[KIND_READ], full_refusals, bad_slots);
    $display("Table filled %0d times and emptied %0d times; %0d results checked.",
             times_full, times_empty, replies_checked);
    if (mismatches == 0 && due_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, due_replies.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sst_pkg.sv
hdl/sst_ram.sv
hdl/sst_ctrl.sv
hdl/sorted_schedule_table.sv
test/sorted_schedule_table_tb.sv
